### sv/meter_response_frame_checker_core_defines.svh
// Assertion macros shared by the meter response frame checker RTL.
// Depends on nothing; the files that check their own logic include it.
`ifndef METER_RESPONSE_FRAME_CHECKER_CORE_DEFINES_SVH
`define METER_RESPONSE_FRAME_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define MRFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame checker assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define MRFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame checker assertion failed");

`endif

### sv/mrfc_pkg.sv
// Types, constants and the CRC step shared by the meter response frame checker.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package mrfc_pkg;

	localparam int MAX_FRAME           = 32;
	localparam int MIN_FRAME           = 23;
	localparam int BYTE_COUNT_POS      = 2;
	localparam int BYTE_COUNT_OVERHEAD = 5;
	localparam int CRC_FIRST_POS       = 2;
	localparam int CAP_FIRST           = 3;
	localparam int CAP_LAST            = 22;
	localparam int CAP_DEPTH           = CAP_LAST - CAP_FIRST + 1;
	localparam int CAP_IDX_W           = $clog2(CAP_DEPTH);
	localparam int QPTR_W              = 2;
	localparam int QUEUE_DEPTH         = 1 << QPTR_W;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam int TDATA_W             = 168;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_CRC_ERR = 2'd1,
		STATUS_LEN_ERR = 2'd2
	} status_t;

	// One classified byte, as the front hands it to the back.
	typedef struct packed {
		logic [7:0]           data;
		logic                 feed_en;
		logic [7:0]           feed_byte;
		logic                 cap_en;
		logic [CAP_IDX_W-1:0] cap_idx;
		logic                 last;
		logic                 len_err;
		logic [15:0]          rx_crc;
	} entry_t;

	typedef struct packed {
		logic [15:0] alarm_status;
		logic [15:0] power_factor;
		logic [15:0] line_frequency;
		logic [31:0] active_energy;
		logic [31:0] active_power;
		logic [31:0] current;
		logic [15:0] voltage;
	} readings_t;

	// One byte of the reflected Modbus CRC-16.
	function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
			input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### sv/mrfc_queue.sv
// Short first-in first-out queue of classified bytes between front and back.
// Depends on mrfc_pkg for the entry type and the queue depth.
`default_nettype none

module mrfc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire mrfc_pkg::entry_t push_entry,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output mrfc_pkg::entry_t     pop_entry
);
	import mrfc_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

`default_nettype wire

### sv/mrfc_front.sv
// Front of the frame checker: counts bytes, keeps the tail pair, judges the length.
// Depends on mrfc_pkg for the entry type and the frame constants.
`default_nettype none

module mrfc_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   in_byte,
	input  wire logic         in_last,
	output logic              push_valid,
	input  wire logic         push_ready,
	output mrfc_pkg::entry_t  push_entry
);
	import mrfc_pkg::*;

	logic [7:0]  pos_q;
	logic        ovf_q;
	logic [15:0] tail_q;
	logic [7:0]  byte2_q;
	logic        accept;
	logic [7:0]  len_next;
	logic        ovf_next;
	logic [7:0]  byte2;
	logic [8:0]  count_sum;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	always_comb begin
		ovf_next  = ovf_q || (pos_q == 8'hFF);
		len_next  = (pos_q == 8'hFF) ? 8'hFF : pos_q + 8'd1;
		byte2     = (pos_q == 8'(BYTE_COUNT_POS)) ? in_byte : byte2_q;
		count_sum = {1'b0, byte2} + 9'(BYTE_COUNT_OVERHEAD);

		push_entry.data      = in_byte;
		push_entry.feed_en   = (pos_q >= 8'(CRC_FIRST_POS));
		push_entry.feed_byte = tail_q[7:0];
		push_entry.cap_en    = pos_q inside {[8'(CAP_FIRST):8'(CAP_LAST)]};
		push_entry.cap_idx   = CAP_IDX_W'(pos_q - 8'(CAP_FIRST));
		push_entry.last      = in_last;
		push_entry.len_err   = ovf_next || (len_next < 8'(MIN_FRAME)) ||
			(len_next > 8'(MAX_FRAME)) || (count_sum != {1'b0, len_next});
		push_entry.rx_crc    = {in_byte, tail_q[15:8]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ovf_q  <= 1'b0;
			tail_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				pos_q  <= '0;
				ovf_q  <= 1'b0;
				tail_q <= '0;
			end else begin
				pos_q  <= len_next;
				ovf_q  <= ovf_next;
				tail_q <= {in_byte, tail_q[15:8]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (pos_q == 8'(BYTE_COUNT_POS))) byte2_q <= in_byte;
	end

endmodule

`default_nettype wire

### sv/mrfc_back.sv
// Back of the frame checker: CRC, byte capture, verdict and the result register.
// Depends on mrfc_pkg and on the assertion macros header.
`default_nettype none
`include "meter_response_frame_checker_core_defines.svh"

module mrfc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pop_valid,
	output logic               pop_ready,
	input  wire mrfc_pkg::entry_t pop_entry,
	output logic               out_valid,
	input  wire logic          out_ready,
	output mrfc_pkg::status_t  out_status,
	output mrfc_pkg::readings_t out_readings
);
	import mrfc_pkg::*;

	logic [15:0] crc_q;
	logic [7:0]  cap_q [CAP_DEPTH];
	logic        fin_valid_s1;
	logic [15:0] fin_crc_s1;
	logic [15:0] rx_crc_s1;
	logic        len_err_s1;
	status_t     status_q;
	readings_t   readings_q;
	logic        m_tvalid_q;
	logic        s2_fire;
	logic        pop;
	logic [15:0] crc_next;
	status_t     status_next;
	readings_t   unpacked;
	logic        verdict_stuck;

	assign s2_fire   = fin_valid_s1 && (!m_tvalid_q || out_ready);
	assign pop_ready = !fin_valid_s1 || s2_fire;
	assign pop       = pop_valid && pop_ready;
	assign crc_next  = pop_entry.feed_en ? crc16_feed(crc_q, pop_entry.feed_byte) : crc_q;

	// A verdict is waiting but the output register cannot take it yet.
	assign verdict_stuck = fin_valid_s1 && !s2_fire;

	assign out_valid    = m_tvalid_q;
	assign out_status   = status_q;
	assign out_readings = readings_q;

	// Captured entry i holds frame byte i + CAP_FIRST; words arrive high byte first.
	always_comb begin
		unpacked.voltage        = {cap_q[0], cap_q[1]};
		unpacked.current        = {cap_q[4], cap_q[5], cap_q[2], cap_q[3]};
		unpacked.active_power   = {cap_q[8], cap_q[9], cap_q[6], cap_q[7]};
		unpacked.active_energy  = {cap_q[12], cap_q[13], cap_q[10], cap_q[11]};
		unpacked.line_frequency = {cap_q[14], cap_q[15]};
		unpacked.power_factor   = {cap_q[16], cap_q[17]};
		unpacked.alarm_status   = {cap_q[18], cap_q[19]};
		if (len_err_s1) status_next = STATUS_LEN_ERR;
		else if (rx_crc_s1 != fin_crc_s1) status_next = STATUS_CRC_ERR;
		else status_next = STATUS_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q        <= CRC_INIT;
			fin_valid_s1 <= 1'b0;
			m_tvalid_q   <= 1'b0;
			status_q     <= STATUS_OK;
			readings_q   <= '0;
		end else begin
			if (pop) crc_q <= pop_entry.last ? CRC_INIT : crc_next;
			if (pop && pop_entry.last) fin_valid_s1 <= 1'b1;
			else if (s2_fire) fin_valid_s1 <= 1'b0;
			if (s2_fire) begin
				m_tvalid_q <= 1'b1;
				status_q   <= status_next;
				if (status_next == STATUS_OK) readings_q <= unpacked;
			end else if (out_ready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_entry.cap_en) cap_q[pop_entry.cap_idx] <= pop_entry.data;
		if (pop && pop_entry.last) begin
			fin_crc_s1 <= crc_next;
			rx_crc_s1  <= pop_entry.rx_crc;
			len_err_s1 <= pop_entry.len_err;
		end
	end

	`MRFC_ASSERT_NXT(a_verdict_loads_result, clk, arst_n, s2_fire, m_tvalid_q)
	`MRFC_ASSERT_NXT(a_pending_verdict_holds, clk, arst_n, verdict_stuck, fin_valid_s1)
	`MRFC_ASSERT_NXT(a_verdict_stable, clk, arst_n, verdict_stuck, $stable({rx_crc_s1, fin_crc_s1}))
	`MRFC_ASSERT_NXT(a_no_repeated_result, clk, arst_n, m_tvalid_q && out_ready && !s2_fire, !m_tvalid_q)
	`MRFC_ASSERT_IMP(a_no_pop_while_stuck, clk, arst_n, verdict_stuck, !pop)

endmodule

`default_nettype wire

### sv/meter_response_frame_checker_core.sv
// Top level of the meter response frame checker: front, byte queue and back.
// Depends on mrfc_pkg, mrfc_front, mrfc_queue and mrfc_back.
//
// Usage: the slave stream carries one received byte of a Modbus RTU meter
// response per word, with s_tlast high on the last byte of the frame. The
// master stream gives exactly one result word per frame: a status code
// (accepted, CRC mismatch, or length and byte count error) and the seven
// readings of the last accepted frame, which are zero after reset.
// Throughput is one byte per cycle: the front takes a word every cycle that
// the four-entry byte queue has room, and the back retires one queued byte a
// cycle through its one-byte CRC step while no verdict waits. A frame's last
// byte goes through the queue and the verdict register before m_tvalid rises.
// When the receiver holds m_tready low, the result stays in the output
// register; the back keeps retiring bytes until it reaches the next frame's
// last byte, then waits, and the front keeps taking bytes until the queue
// fills. Reset clears the byte count, the CRC, the queue and the readings,
// and drops m_tvalid; no clearing pass is needed, so s_tready rises as soon
// as reset is released.
`default_nettype none

module meter_response_frame_checker_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,   // rx_byte
	input  wire logic                          s_tlast,   // frame_end
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// status[1:0], voltage[17:2], current[49:18], active_power[81:50],
	// active_energy[113:82], line_frequency[129:114], power_factor[145:130],
	// alarm_status[161:146], zero fill above
	output logic [mrfc_pkg::TDATA_W-1:0]       m_tdata
);
	import mrfc_pkg::*;

	logic      push_valid;
	logic      push_ready;
	entry_t    push_entry;
	logic      pop_valid;
	logic      pop_ready;
	entry_t    pop_entry;
	status_t   status;
	readings_t readings;

	// The front classifies each byte as it arrives: CRC feed, capture slot and
	// the length verdict, from the byte position so far and the byte count field.
	mrfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	mrfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// The back runs the CRC, stores the payload bytes and forms the result.
	mrfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_entry    (pop_entry),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_status   (status),
		.out_readings (readings)
	);

	// The readings struct is declared highest field first, so it packs
	// voltage at the bottom, right above the status.
	assign m_tdata = {6'b0, readings, status};

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for meter_response_frame_checker_core: builds Modbus RTU meter
// responses, streams them byte by byte and checks every result word against its own model.
// Depends on mrfc_pkg for the status codes, the readings layout and the frame limits.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CAPTURE_SPAN    = 23;      // bytes 0..22 of a frame are kept
	localparam int          TDATA_W         = mrfc_pkg::TDATA_W;
	localparam int          READINGS_LSB    = 2;
	localparam int          READINGS_MSB    = 161;
	localparam logic [7:0]  READ_INPUT_REGS = 8'h04;
	localparam int          WORD_TARGET     = 1500;
	localparam int          FRAME_TARGET    = 60;
	localparam int          DRAIN_CYCLES    = 16;
	localparam int unsigned CYCLE_LIMIT     = 400000;

	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_CRC,
		FRAME_BAD_COUNT,
		FRAME_RAW
	} frame_kind_t;

	typedef enum int {
		FILL_RANDOM,
		FILL_ZEROS,
		FILL_ONES
	} fill_t;

	// One byte waiting to go out; hold makes the sender wait for all results first.
	typedef struct {
		logic [7:0] b;
		logic       fin;
		bit         hold;
	} rx_word_t;

	typedef struct {
		mrfc_pkg::status_t   status;
		mrfc_pkg::readings_t readings;
	} meter_result_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata  = '0;
	logic                s_tlast  = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;

	rx_word_t      rx_stream[$];
	meter_result_t awaited_results[$];

	int          words_queued  = 0;
	int          frames_queued = 0;
	int          huge_frames   = 0;
	int          mismatches    = 0;
	int          results_seen  = 0;
	int          tx_wait       = 0;
	int          rx_wait       = 0;
	int unsigned cycles        = 0;
	bit          calm          = 1'b0;

	// Model state of the frame being received and of the last accepted readings.
	logic [15:0]         sum_crc         = mrfc_pkg::CRC_INIT;
	int                  byte_count      = 0;
	logic [15:0]         tail_pair       = '0;
	bit                  count_saturated = 1'b0;
	logic [7:0]          frame_bytes [CAPTURE_SPAN] = '{default: 8'h00};
	mrfc_pkg::readings_t meter           = '0;

	meter_response_frame_checker_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// Reflected CRC-16 worked one data bit at a time: the feedback bit is the
	// low CRC bit xor the incoming bit, taken least significant first.
	function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r  = r >> 1;
			if (fb)
				r = r ^ mrfc_pkg::CRC_POLY;
		end
		return r;
	endfunction

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 3);
	endfunction

	// Advances the frame model by one accepted byte. The last byte of a frame
	// decides the status, updates the readings on success and queues the result.
	function automatic void absorb_byte(input logic [7:0] b, input logic fin);
		meter_result_t r;
		// A byte only enters the CRC once it has been pushed out of the tail
		// pair, so the two CRC bytes at the end never get summed.
		if (byte_count >= 2)
			sum_crc = crc_step(sum_crc, tail_pair[7:0]);
		tail_pair = {b, tail_pair[15:8]};
		if (byte_count < CAPTURE_SPAN)
			frame_bytes[byte_count] = b;
		if (byte_count == 255)
			count_saturated = 1'b1;
		else
			byte_count++;
		if (fin) begin
			// The length test comes first, so byte 2 is only looked at once the
			// frame is known to have written it.
			if (count_saturated || byte_count < mrfc_pkg::MIN_FRAME ||
					byte_count > mrfc_pkg::MAX_FRAME ||
					int'(frame_bytes[2]) + 5 != byte_count) begin
				r.status = mrfc_pkg::STATUS_LEN_ERR;
			end else if (tail_pair != sum_crc) begin
				r.status = mrfc_pkg::STATUS_CRC_ERR;
			end else begin
				r.status = mrfc_pkg::STATUS_OK;
				// Registers are big endian; 32-bit values send the low word first.
				meter.voltage        = {frame_bytes[3], frame_bytes[4]};
				meter.current        = {frame_bytes[7], frame_bytes[8],
						frame_bytes[5], frame_bytes[6]};
				meter.active_power   = {frame_bytes[11], frame_bytes[12],
						frame_bytes[9], frame_bytes[10]};
				meter.active_energy  = {frame_bytes[15], frame_bytes[16],
						frame_bytes[13], frame_bytes[14]};
				meter.line_frequency = {frame_bytes[17], frame_bytes[18]};
				meter.power_factor   = {frame_bytes[19], frame_bytes[20]};
				meter.alarm_status   = {frame_bytes[21], frame_bytes[22]};
			end
			r.readings = meter;
			awaited_results.push_back(r);
			sum_crc         = mrfc_pkg::CRC_INIT;
			byte_count      = 0;
			tail_pair       = '0;
			count_saturated = 1'b0;
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d, %s: expected %h, got %h", results_seen, name, want, got);
		end
	endfunction

	// Builds one response frame of len bytes and appends it to the send queue.
	// Structured kinds carry a function code (mostly 04), the byte count and a CRC;
	// the bad kinds then break exactly one of those.
	task automatic queue_frame(input int len, input frame_kind_t kind, input fill_t fill,
			input bit hold);
		logic [7:0]  fb[$];
		logic [15:0] crc;
		int          pos;
		rx_word_t    w;
		for (int i = 0; i < len; i++) begin
			case (fill)
				FILL_ZEROS: fb.push_back(8'h00);
				FILL_ONES:  fb.push_back(8'hFF);
				default:    fb.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		if (kind != FRAME_RAW && len >= 5) begin
			fb[1] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : READ_INPUT_REGS;
			fb[2] = 8'(len - 5);
			if (kind == FRAME_BAD_COUNT)
				fb[2] = 8'(len - 5 + $urandom_range(1, 255));
			crc = mrfc_pkg::CRC_INIT;
			for (int i = 0; i < len - 2; i++)
				crc = crc_step(crc, fb[i]);
			fb[len-2] = crc[7:0];
			fb[len-1] = crc[15:8];
			if (kind == FRAME_BAD_CRC) begin
				// A single flipped bit anywhere but the byte count is always caught.
				pos = $urandom_range(0, len - 2);
				if (pos >= 2)
					pos++;
				fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(0, 7));
			end
		end
		for (int i = 0; i < len; i++) begin
			w.b    = fb[i];
			w.fin  = (i == len - 1);
			w.hold = hold && (i == 0);
			rx_stream.push_back(w);
		end
		words_queued += len;
		frames_queued++;
	endtask

	// Sender: a word is taken at an edge where tvalid and tready are both high.
	// The model sees it at that same edge, before the next word is chosen.
	always @(posedge clk or negedge arst_n) begin
		rx_word_t next_word;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
			tx_wait  <= 0;
		end else begin
			if (s_tvalid && s_tready)
				absorb_byte(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (tx_wait > 0) begin
					s_tvalid <= 1'b0;
					tx_wait  <= tx_wait - 1;
				end else if (rx_stream.size() != 0 &&
						!(rx_stream[0].hold && awaited_results.size() != 0)) begin
					next_word = rx_stream.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_word.b;
					s_tlast  <= next_word.fin;
					tx_wait  <= draw_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result word against the oldest prediction, then
	// holds tready low for a freshly drawn number of cycles.
	always @(posedge clk or negedge arst_n) begin
		meter_result_t       want;
		mrfc_pkg::readings_t got;
		int                  w;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait  <= 0;
		end else if (m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with none expected", results_seen);
			end else begin
				want = awaited_results.pop_front();
				got  = mrfc_pkg::readings_t'(m_tdata[READINGS_MSB:READINGS_LSB]);
				check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
				check_field("voltage", 32'(want.readings.voltage), 32'(got.voltage));
				check_field("current", want.readings.current, got.current);
				check_field("active_power", want.readings.active_power, got.active_power);
				check_field("active_energy", want.readings.active_energy,
						got.active_energy);
				check_field("line_frequency", 32'(want.readings.line_frequency),
						32'(got.line_frequency));
				check_field("power_factor", 32'(want.readings.power_factor),
						32'(got.power_factor));
				check_field("alarm_status", 32'(want.readings.alarm_status),
						32'(got.alarm_status));
				check_field("zero fill", 32'h0, 32'(m_tdata[TDATA_W-1:READINGS_MSB+1]));
			end
			results_seen++;
			w = draw_gap();
			m_tready <= (w == 0);
			rx_wait  <= (w == 0) ? 0 : w - 1;
		end else if (rx_wait > 0) begin
			m_tready <= 1'b0;
			rx_wait  <= rx_wait - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Cycle count for the timeout; each time the low byte of the count wraps to zero,
	// decide afresh whether both sides run without gaps for a while.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles[7:0] == 8'd0)
			calm <= ($urandom_range(0, 2) == 0);
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int    roll;
		int    len;
		fill_t fill;
		bit    hold;

		// Directed: a shortest valid frame of ones but for function code, byte count and CRC,
		// then a frame that ends on its very first byte.
		queue_frame(mrfc_pkg::MIN_FRAME, FRAME_GOOD, FILL_ONES, 1'b0);
		queue_frame(1, FRAME_RAW, FILL_ZEROS, 1'b0);

		// Random: mostly well-formed frames with random content, the rest split
		// among CRC damage, wrong byte counts, short, long and saturating frames.
		while (words_queued < WORD_TARGET || frames_queued < FRAME_TARGET) begin
			roll = $urandom_range(0, 99);
			fill = ($urandom_range(0, 7) == 0) ? fill_t'($urandom_range(1, 2)) : FILL_RANDOM;
			hold = (frames_queued % 12 == 5);
			if ($urandom_range(0, 3) == 0)
				len = $urandom_range(0, 1) ? mrfc_pkg::MIN_FRAME : mrfc_pkg::MAX_FRAME;
			else
				len = $urandom_range(mrfc_pkg::MIN_FRAME, mrfc_pkg::MAX_FRAME);
			if (roll < 60) begin
				queue_frame(len, FRAME_GOOD, fill, hold);
			end else if (roll < 72) begin
				queue_frame(len, FRAME_BAD_CRC, fill, hold);
			end else if (roll < 82) begin
				queue_frame(len, FRAME_BAD_COUNT, fill, hold);
			end else if (roll < 90) begin
				queue_frame($urandom_range(1, mrfc_pkg::MIN_FRAME - 1), FRAME_RAW, fill, hold);
			end else if (roll < 97) begin
				queue_frame($urandom_range(mrfc_pkg::MAX_FRAME + 1, 64), FRAME_GOOD, fill, hold);
			end else if (huge_frames < 3) begin
				// Lengths on both sides of the 255-byte count; those past 255 bytes saturate it.
				queue_frame($urandom_range(254, 262), FRAME_GOOD, fill, hold);
				huge_frames++;
			end else begin
				queue_frame(mrfc_pkg::MAX_FRAME, FRAME_GOOD, fill, hold);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_stream.size() != 0 || s_tvalid)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && awaited_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
